// ===== hw/rtl/smt_pkg.sv =====
package smt_pkg;

    typedef struct packed {
        logic signed [15:0] logit;
        logic               is_last;
    } t_in_item;

    typedef struct packed {
        logic [15:0] probability;
        logic        is_last_res;
        logic        overflow;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_EXP_RD,
        ST_EXP_GO,
        ST_EXP_DIV,
        ST_EXP_MUL,
        ST_EXP_ITER,
        ST_EXP_WR,
        ST_NRM_RD,
        ST_NRM_GO,
        ST_NRM_DIV,
        ST_NRM_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // store the accepted logit
        logic drop;        // the accepted logit found the store full
        logic clear;       // return vector state to reset values
        logic div_exp;     // start d<<16 / T
        logic div_nrm;     // start e<<16 / sum
        logic mul_log2e;   // scale quotient by log2(e)
        logic iter_init;   // start the fraction-bit iteration
        logic iter_step;   // one fraction bit
        logic wr_exp;      // write e_i and accumulate
        logic idx_clr;
        logic idx_inc;
        logic emit;
    } t_ctrl;

    typedef struct packed {
        logic div_done;
        logic iter_done;
        logic idx_last;
        logic full;
    } t_stat;

    localparam logic [16:0] Log2eQ16 = 17'd94548;

    function automatic logic [15:0] pow2_neg_frac(input logic [3:0] i);
        logic [15:0] c;
        begin
            case (i)
                4'd0:  c = 16'd46341;
                4'd1:  c = 16'd55109;
                4'd2:  c = 16'd60097;
                4'd3:  c = 16'd62757;
                4'd4:  c = 16'd64132;
                4'd5:  c = 16'd64830;
                4'd6:  c = 16'd65182;
                4'd7:  c = 16'd65359;
                4'd8:  c = 16'd65447;
                4'd9:  c = 16'd65492;
                4'd10: c = 16'd65514;
                4'd11: c = 16'd65525;
                4'd12: c = 16'd65530;
                4'd13: c = 16'd65533;
                default: c = 16'd65535;
            endcase
            return c;
        end
    endfunction

endpackage

// ===== hw/rtl/smt_ram.sv =====
module smt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/smt_div.sv =====
module smt_div #(
    parameter int DW = 23
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [32:0]   i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [32:0]   o_quot
);
    // Restoring divider, one quotient bit per cycle over a 33-bit dividend.
    logic [32:0]   r_quot, n_quot;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_dvs, n_dvs;
    logic [5:0]    r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic [DW:0]   trial;

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        trial  = {r_rem, r_quot[32]};
        if (i_start) begin
            n_quot = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_cnt  = 6'd33;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dvs}) begin
                n_rem  = DW'(trial - {1'b0, r_dvs});
                n_quot = {r_quot[31:0], 1'b1};
            end else begin
                n_rem  = trial[DW-1:0];
                n_quot = {r_quot[31:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
    end

    assign o_done = r_busy && (r_cnt == 6'd1);
    assign o_quot = n_quot;
endmodule

// ===== hw/rtl/smt_datapath.sv =====
module smt_datapath #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  smt_pkg::t_ctrl    i_ctrl,
    input  smt_pkg::t_in_item i_item,
    input  logic [15:0]       i_temperature,
    output smt_pkg::t_stat    o_stat,
    output smt_pkg::t_out_item o_item
);
    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    // Holds the sum of up to MAX_ELEMENTS exponentials of at most 1.0 each.
    localparam int SW = AW + 17;

    logic [CW-1:0]        r_count;
    logic signed [15:0]   r_max;
    logic [SW-1:0]        r_sum;
    logic                 r_dropped;
    logic [CW-1:0]        r_idx;
    logic [31:0]          r_z;
    logic [15:0]          r_frac;
    logic [16:0]          r_k;
    logic [16:0]          r_acc;
    logic [3:0]           r_bit;
    logic [32:0]          div_quot;
    logic                 div_done;
    logic [15:0]          logit_rd;
    logic [16:0]          exp_rd;
    logic [16:0]          exp_val;
    logic [15:0]          diff;
    logic [48:0]          y_full;
    logic [15:0]          pow2_c;
    logic [32:0]          prod;
    logic [32:0]          div_a;
    logic [SW-1:0]        div_b;
    logic [AW-1:0]        raddr;
    logic [15:0]          prob;

    assign raddr = r_idx[AW-1:0];

    smt_ram #(.WIDTH(16), .DEPTH(MAX_ELEMENTS)) u_logit_ram (
        .i_clk  (i_clk),
        .i_we   (i_ctrl.load),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(i_item.logit),
        .i_raddr(raddr),
        .o_rdata(logit_rd)
    );

    smt_ram #(.WIDTH(17), .DEPTH(MAX_ELEMENTS)) u_exp_ram (
        .i_clk  (i_clk),
        .i_we   (i_ctrl.wr_exp),
        .i_waddr(raddr),
        .i_wdata(exp_val),
        .i_raddr(raddr),
        .o_rdata(exp_rd)
    );

    assign diff  = 16'(r_max - $signed(logit_rd));
    // The maximum element has e = 1.0, so its normalize numerator needs 33 bits.
    assign div_a = i_ctrl.div_nrm ? {exp_rd, 16'd0} : {1'b0, diff, 16'd0};
    assign div_b = i_ctrl.div_nrm ? r_sum : SW'(i_temperature);

    smt_div #(.DW(SW)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_ctrl.div_exp | i_ctrl.div_nrm),
        .i_dividend(div_a),
        .i_divisor (div_b),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    assign y_full  = r_z * smt_pkg::Log2eQ16;
    assign pow2_c  = smt_pkg::pow2_neg_frac(r_bit);
    assign prod    = r_acc * pow2_c;
    assign exp_val = (r_k > 17'd16) ? 17'd0 : (r_acc >> r_k[4:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_max     <= 16'sh8000;
            r_sum     <= '0;
            r_dropped <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (i_ctrl.clear) begin
                r_count   <= '0;
                r_max     <= 16'sh8000;
                r_sum     <= '0;
                r_dropped <= 1'b0;
            end else if (i_ctrl.load) begin
                r_count <= r_count + CW'(1);
                if (i_item.logit > r_max) begin
                    r_max <= i_item.logit;
                end
            end else if (i_ctrl.drop) begin
                r_dropped <= 1'b1;
            end else if (i_ctrl.wr_exp) begin
                r_sum <= r_sum + SW'(exp_val);
            end
            if (i_ctrl.idx_clr) begin
                r_idx <= '0;
            end else if (i_ctrl.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_done) begin
            r_z <= div_quot[31:0];
        end
        if (i_ctrl.mul_log2e) begin
            r_k    <= y_full[48:32];
            r_frac <= y_full[31:16];
        end
        if (i_ctrl.iter_init) begin
            r_acc <= 17'h10000;
            r_bit <= '0;
        end else if (i_ctrl.iter_step) begin
            if (r_frac[4'd15 - r_bit]) begin
                r_acc <= 17'((prod + 33'd32768) >> 16);
            end
            r_bit <= r_bit + 4'd1;
        end
    end

    assign prob = (div_quot > 33'd65535) ? 16'hFFFF : div_quot[15:0];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit) begin
            o_item.probability <= prob;
            o_item.is_last_res <= o_stat.idx_last;
            o_item.overflow    <= r_dropped;
        end
    end

    assign o_stat.div_done  = div_done;
    assign o_stat.iter_done = (r_bit == 4'd15);
    assign o_stat.idx_last  = (r_idx + CW'(1) == r_count);
    assign o_stat.full      = (r_count == CW'(MAX_ELEMENTS));
endmodule

// ===== hw/rtl/smt_ctrl.sv =====
module smt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_is_last,
    input  smt_pkg::t_stat    i_stat,
    output smt_pkg::t_ctrl    o_ctrl,
    output logic              o_busy,
    output logic              o_strobe
);
    smt_pkg::t_state r_state, n_state;
    logic            r_strobe;
    logic            accept;

    assign accept = i_start && (r_state == smt_pkg::ST_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= smt_pkg::ST_LOAD;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= o_ctrl.emit;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        case (r_state)
            smt_pkg::ST_LOAD: begin
                if (accept) begin
                    o_ctrl.load = !i_stat.full;
                    o_ctrl.drop = i_stat.full;
                    // A closing item always leaves at least one element stored.
                    if (i_is_last) begin
                        o_ctrl.idx_clr = 1'b1;
                        n_state = smt_pkg::ST_EXP_RD;
                    end
                end
            end
            smt_pkg::ST_EXP_RD: begin
                n_state = smt_pkg::ST_EXP_GO;
            end
            smt_pkg::ST_EXP_GO: begin
                o_ctrl.div_exp = 1'b1;
                n_state = smt_pkg::ST_EXP_DIV;
            end
            smt_pkg::ST_EXP_DIV: begin
                if (i_stat.div_done) begin
                    n_state = smt_pkg::ST_EXP_MUL;
                end
            end
            smt_pkg::ST_EXP_MUL: begin
                o_ctrl.mul_log2e = 1'b1;
                o_ctrl.iter_init = 1'b1;
                n_state = smt_pkg::ST_EXP_ITER;
            end
            smt_pkg::ST_EXP_ITER: begin
                o_ctrl.iter_step = 1'b1;
                if (i_stat.iter_done) begin
                    n_state = smt_pkg::ST_EXP_WR;
                end
            end
            smt_pkg::ST_EXP_WR: begin
                o_ctrl.wr_exp = 1'b1;
                if (i_stat.idx_last) begin
                    o_ctrl.idx_clr = 1'b1;
                    n_state = smt_pkg::ST_NRM_RD;
                end else begin
                    o_ctrl.idx_inc = 1'b1;
                    n_state = smt_pkg::ST_EXP_RD;
                end
            end
            smt_pkg::ST_NRM_RD: begin
                n_state = smt_pkg::ST_NRM_GO;
            end
            smt_pkg::ST_NRM_GO: begin
                o_ctrl.div_nrm = 1'b1;
                n_state = smt_pkg::ST_NRM_DIV;
            end
            smt_pkg::ST_NRM_DIV: begin
                if (i_stat.div_done) begin
                    o_ctrl.emit = 1'b1;
                    n_state = smt_pkg::ST_NRM_OUT;
                end
            end
            smt_pkg::ST_NRM_OUT: begin
                if (i_stat.idx_last) begin
                    o_ctrl.clear = 1'b1;
                    n_state = smt_pkg::ST_LOAD;
                end else begin
                    o_ctrl.idx_inc = 1'b1;
                    n_state = smt_pkg::ST_NRM_RD;
                end
            end
            default: n_state = smt_pkg::ST_LOAD;
        endcase
    end

    assign o_busy   = (r_state != smt_pkg::ST_LOAD);
    assign o_strobe = r_strobe;
endmodule

// ===== hw/rtl/softmax_with_temperature.sv =====
// Softmax with temperature. Logits are loaded one per cycle while busy is
// low; the item marked last closes the vector and busy rises. Each element
// then gets its exponential (read, start, a divide by the temperature,
// scaling, 16 fraction-bit steps and write) and its normalization
// (read, start, a divide by the sum and output), all on one shared serial
// divider. Results come out one at a time, each on the strobe for one cycle,
// and cannot be stalled; busy falls the cycle after the last one.
// Temperature writes are taken any time and a write of zero is stored as one.
module softmax_with_temperature #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  smt_pkg::t_in_item  i_item,
    output logic               o_strobe,
    output smt_pkg::t_out_item o_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data
);
    smt_pkg::t_ctrl ctrl;
    smt_pkg::t_stat stat;
    logic [15:0]    r_temperature;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temperature <= 16'd256;
        end else if (i_cfg_valid) begin
            r_temperature <= (i_cfg_data == 16'd0) ? 16'd1 : i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    smt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_is_last(i_item.is_last),
        .i_stat   (stat),
        .o_ctrl   (ctrl),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    smt_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_item       (i_item),
        .i_temperature(r_temperature),
        .o_stat       (stat),
        .o_item       (o_item)
    );
endmodule

// ===== hw/rtl/smt_checker.sv =====
module smt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe,
    input logic o_cfg_ready
);
    a_no_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy)) else $error("strobe outside busy");
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start)) else $error("busy without start");
    a_no_double_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("back to back strobes");
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready) else $error("cfg not ready");
endmodule

bind softmax_with_temperature smt_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_strobe   (o_strobe),
    .o_cfg_ready(o_cfg_ready)
);

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int MaxElems = 64;
    localparam int CycleLimit = 2000000;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    smt_pkg::t_in_item   i_item;
    logic       o_strobe;
    smt_pkg::t_out_item  o_item;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [15:0] i_cfg_data;

    softmax_with_temperature #(.MAX_ELEMENTS(MaxElems)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_strobe(o_strobe), .o_item(o_item),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // Predictor state.
    logic [15:0]        temp_q88;
    logic signed [15:0] logits [MaxElems];
    int                 n_stored;
    logic signed [15:0] vec_max;
    bit                 vec_dropped;

    smt_pkg::t_in_item  pending_logits [$];
    smt_pkg::t_out_item expected_probs [$];
    bit        idle_gaps;
    bit        failed;
    int        cycles;

    logic [16:0] frac_consts [16];

    function automatic logic [16:0] exp_of_gap(input logic [15:0] d, input logic [15:0] t);
        logic [63:0] z;
        logic [63:0] y;
        logic [63:0] acc;
        logic [15:0] f;
        int          k;
        z = {32'd0, d, 16'd0} / {48'd0, t};
        y = (z * 64'd94548) >> 16;
        k = int'(y >> 16);
        f = y[15:0];
        acc = 64'd65536;
        if (y[63:16] > 48'd16) return 17'd0;
        for (int i = 0; i < 16; i++)
            if (f[15 - i]) acc = (acc * {47'd0, frac_consts[i]} + 64'd32768) >> 16;
        return 17'((acc >> k));
    endfunction

    task automatic predict_vector(input smt_pkg::t_in_item it);
        logic [16:0] e [MaxElems];
        logic [31:0] total;
        logic [63:0] p;
        smt_pkg::t_out_item r;
        if (n_stored < MaxElems) begin
            logits[n_stored] = it.logit;
            n_stored++;
            if (it.logit > vec_max) vec_max = it.logit;
        end else begin
            vec_dropped = 1'b1;
        end
        if (!it.is_last) return;
        total = 0;
        for (int i = 0; i < n_stored; i++) begin
            e[i] = exp_of_gap(16'(vec_max - logits[i]), temp_q88);
            total += e[i];
        end
        for (int i = 0; i < n_stored; i++) begin
            p = {31'd0, e[i], 16'd0} / {32'd0, total};
            r.probability = (p > 64'd65535) ? 16'hFFFF : p[15:0];
            r.is_last_res = (i + 1 == n_stored);
            r.overflow = vec_dropped;
            expected_probs.push_back(r);
        end
        n_stored = 0;
        vec_max = 16'sh8000;
        vec_dropped = 1'b0;
    endtask

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Acceptance is decided at the rising edge; the driver reads it at the next fall.
    bit busy_seen;
    always @(posedge i_clk) begin
        busy_seen <= (i_rst_n && start && !busy);
        if (i_rst_n && start && !busy) begin
            predict_vector(i_item);
        end
    end

    // Driver: one pending logit at a time, with random idle bursts.
    int gap_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left <= 0;
        end else if (start && !busy_seen) begin
            // Held item still waiting.
        end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_logits.size() > 0) begin
            i_item <= pending_logits.pop_front();
            start <= 1'b1;
            if (idle_gaps && $urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 6);
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        smt_pkg::t_out_item want;
        cycles <= cycles + 1;
        if (i_rst_n && o_strobe) begin
            if (expected_probs.size() == 0) begin
                $display("%0t: unexpected result, actual %p", $time, o_item);
                failed = 1'b1;
            end else begin
                want = expected_probs.pop_front();
                if (want.probability !== o_item.probability)
                    $display("%0t: probability expected %0d actual %0d",
                             $time, want.probability, o_item.probability);
                if (want.is_last_res !== o_item.is_last_res)
                    $display("%0t: is_last_res expected %0b actual %0b",
                             $time, want.is_last_res, o_item.is_last_res);
                if (want.overflow !== o_item.overflow)
                    $display("%0t: overflow expected %0b actual %0b",
                             $time, want.overflow, o_item.overflow);
                if (want !== o_item) failed = 1'b1;
            end
        end
        if (cycles > CycleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_logits.size() > 0 || start || expected_probs.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_temperature(input logic [15:0] t);
        @(negedge i_clk);
        i_cfg_data <= t;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        temp_q88 = (t == 16'd0) ? 16'd1 : t;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_vector(input int len, input int mode);
        smt_pkg::t_in_item it;
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: it.logit = 16'($urandom);
                1: it.logit = 16'($signed($urandom_range(0, 2047)) - 1024);
                default: it.logit = 16'($signed($urandom_range(0, 255)) - 128);
            endcase
            it.is_last = (i == len - 1);
            pending_logits.push_back(it);
        end
    endtask

    function automatic smt_pkg::t_in_item mk(input logic signed [15:0] x, input logic l);
        smt_pkg::t_in_item it;
        it.logit = x;
        it.is_last = l;
        return it;
    endfunction

    initial begin
        logic [15:0] temps [6];
        frac_consts = '{46341, 55109, 60097, 62757, 64132, 64830, 65182, 65359,
                        65447, 65492, 65514, 65525, 65530, 65533, 65535, 65535};
        temps = '{16'd0, 16'd1, 16'd256, 16'd64, 16'd4096, 16'hFFFF};
        temp_q88 = 16'd256;
        n_stored = 0;
        vec_max = 16'sh8000;
        vec_dropped = 1'b0;
        failed = 1'b0;
        cycles = 0;
        idle_gaps = 1'b1;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: single element, extremes, ties, then a full store.
        pending_logits.push_back(mk(16'sd0, 1'b1));
        pending_logits.push_back(mk(16'sh7FFF, 1'b0));
        pending_logits.push_back(mk(-16'sd32768, 1'b1));
        pending_logits.push_back(mk(16'sd5, 1'b0));
        pending_logits.push_back(mk(16'sd5, 1'b0));
        pending_logits.push_back(mk(-16'sd1, 1'b0));
        pending_logits.push_back(mk(16'sh5555, 1'b0));
        pending_logits.push_back(mk(-16'sh5556, 1'b1));
        wait_drained();
        write_temperature(16'd0);
        pending_logits.push_back(mk(16'sd0, 1'b0));
        pending_logits.push_back(mk(-16'sd1, 1'b0));
        pending_logits.push_back(mk(-16'sd300, 1'b1));
        wait_drained();
        write_temperature(16'hFFFF);
        pending_logits.push_back(mk(16'sh7FFF, 1'b0));
        pending_logits.push_back(mk(-16'sd32768, 1'b1));
        wait_drained();
        write_temperature(16'd256);
        // Overfull vector, closing item dropped as well.
        queue_vector(MaxElems + 3, 1);
        wait_drained();

        for (int ph = 0; ph < 12; ph++) begin
            write_temperature(ph < 6 ? temps[ph] : 16'($urandom_range(1, 1024)));
            if (ph >= 10) idle_gaps = 1'b0;
            for (int v = 0; v < 3; v++) begin
                if ($urandom_range(0, 39) == 0) queue_vector(MaxElems + $urandom_range(1, 3), 0);
                else queue_vector($urandom_range(1, 5), $urandom_range(0, 2));
            end
            wait_drained();
        end

        if (!failed)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
